// ===== hw/rtl/rhc_pkg.sv =====
// shared types and constants of the rgb to hsl converter
package rhc_pkg;

  // channel and result field widths
  localparam int CH_W   = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 16;
  localparam int LSUM_W = 9;

  // default fixed-point formats
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_BITS_DEF      = 16;

  // which channel sets the hue sector
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // input word: one pixel
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } in_word_t;

  // output word: hsl form
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [LSUM_W-1:0] lightness_sum;
  } out_word_t;

  // per-item control carried alongside the divider stages
  typedef struct packed {
    sector_t           sec;
    logic              neg;
    logic              grey;
    logic [LSUM_W-1:0] sum;
    logic [CH_W-1:0]   den;
    logic [CH_W-1:0]   delta;
  } side_t;

endpackage

// ===== hw/rtl/rgb_to_hsl_converter_unit.sv =====
// rgb to hsl converter: pipelined top level with two bit-per-stage dividers
//
// Usage
//   Input channel: drive pixel and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy is low except in reset, so
//   a new pixel may be given on every clock.
//   Output channel: done is high for exactly one cycle with the hsl word on
//   result. The receiver cannot hold results off and none is needed: the
//   pipeline advances every cycle.
// Throughput and pipeline
//   One pixel per clock. With QMAX = max(SAT_BITS, clog2(60 * 2^HUE_FRAC_BITS
//   + 1)), a taken pixel passes through two compare/subtract stages, one
//   numerator stage, QMAX restoring divider stages (saturation and hue
//   share the stage count, one quotient bit per stage) and the output
//   register.
// Reset
//   rst clears every valid bit; items in flight are dropped and busy stays
//   high while rst is held.
module rgb_to_hsl_converter_unit #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_BITS      = rhc_pkg::SAT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rhc_pkg::in_word_t pixel,
  output logic              done,
  output rhc_pkg::out_word_t result
);

  localparam int HF_SCALE = 2 ** HUE_FRAC_BITS;
  localparam int QH       = $clog2(60 * HF_SCALE + 1);
  localparam int QMAX     = (SAT_BITS > QH) ? SAT_BITS : QH;
  localparam int NW       = QMAX + 8;
  localparam int HW       = $clog2(360 * HF_SCALE);
  localparam int CW       = (HW > QMAX) ? HW : QMAX;
  localparam int LAT      = QMAX + 4;
  localparam int HUE_OW   = rhc_pkg::HUE_W;
  localparam int SAT_OW   = rhc_pkg::SAT_W;

  localparam logic [CW-1:0] H120 = CW'(120 * HF_SCALE);
  localparam logic [CW-1:0] H240 = CW'(240 * HF_SCALE);
  localparam logic [CW-1:0] H360 = CW'(360 * HF_SCALE);

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [NW-1:0] div_step(input logic [NW-1:0] acc,
                                             input logic [7:0] d);
    logic [8:0] t;
    logic       ge;
    logic [8:0] tr;
    t  = acc[NW-1:QMAX-1];
    ge = (t >= {1'b0, d});
    tr = ge ? (t - {1'b0, d}) : t;
    return {tr[7:0], acc[QMAX-2:0], ge};
  endfunction

  // stage a: max, min, sector and signed channel difference
  logic              a_valid;
  logic [7:0]        a_mx, a_mn;
  logic [8:0]        a_diff;
  rhc_pkg::sector_t  a_sec;

  logic              red_top, green_top;
  logic [7:0]        mx_c, mn_c, x_c, y_c;
  rhc_pkg::sector_t  sec_c;

  assign busy = rst;

  always_comb begin
    red_top   = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
    green_top = (pixel.green >= pixel.blue);
    if (red_top) begin
      sec_c = rhc_pkg::SEC_RED;
      mx_c  = pixel.red;
      x_c   = pixel.green;
      y_c   = pixel.blue;
    end else if (green_top) begin
      sec_c = rhc_pkg::SEC_GREEN;
      mx_c  = pixel.green;
      x_c   = pixel.blue;
      y_c   = pixel.red;
    end else begin
      sec_c = rhc_pkg::SEC_BLUE;
      mx_c  = pixel.blue;
      x_c   = pixel.red;
      y_c   = pixel.green;
    end
    mn_c = pixel.red;
    if (pixel.green < mn_c) mn_c = pixel.green;
    if (pixel.blue < mn_c) mn_c = pixel.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_mx   <= mx_c;
    a_mn   <= mn_c;
    a_sec  <= sec_c;
    a_diff <= {1'b0, x_c} - {1'b0, y_c};
  end

  // stage b: delta, sum, denominator and magnitude of the difference
  logic           b_valid;
  rhc_pkg::side_t b_side;
  logic [7:0]     b_absd;

  logic [8:0]     sum_c, neg_diff_c;
  logic [7:0]     delta_c;

  always_comb begin
    delta_c    = a_mx - a_mn;
    sum_c      = {1'b0, a_mx} + {1'b0, a_mn};
    neg_diff_c = 9'd0 - a_diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_side.sec   <= a_sec;
    b_side.neg   <= a_diff[8];
    b_side.grey  <= (delta_c == 8'd0);
    b_side.sum   <= sum_c;
    b_side.den   <= (sum_c <= 9'd255) ? sum_c[7:0] : 8'(9'd510 - sum_c);
    b_side.delta <= delta_c;
    b_absd       <= a_diff[8] ? neg_diff_c[7:0] : a_diff[7:0];
  end

  // stage c and divider stages: numerators loaded, then one quotient bit each
  logic           d_valid [0:QMAX];
  rhc_pkg::side_t d_side  [0:QMAX];
  logic [NW-1:0]  sacc    [0:QMAX];
  logic [NW-1:0]  hacc    [0:QMAX];

  logic [13:0]    absd60_c;

  assign absd60_c = ({6'd0, b_absd} << 6) - ({6'd0, b_absd} << 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else begin
      d_valid[0] <= b_valid;
    end
    d_side[0] <= b_side;
    sacc[0]   <= (NW'(b_side.delta) << SAT_BITS) - NW'(b_side.delta);
    hacc[0]   <= NW'(absd60_c) << HUE_FRAC_BITS;
  end

  for (genvar k = 1; k <= QMAX; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k] <= 1'b0;
      end else begin
        d_valid[k] <= d_valid[k-1];
      end
      d_side[k] <= d_side[k-1];
      sacc[k]   <= div_step(sacc[k-1], d_side[k-1].den);
      hacc[k]   <= div_step(hacc[k-1], d_side[k-1].delta);
    end
  end

  // final stage: hue from sector base and rounded quotient, output register
  rhc_pkg::side_t fs;
  logic [CW-1:0]  hq_c, base_c, hue_c, sat_c;
  logic           hrem_nz_c;

  always_comb begin
    fs        = d_side[QMAX];
    hq_c      = CW'(hacc[QMAX][QMAX-1:0]);
    hrem_nz_c = |hacc[QMAX][NW-1:QMAX];
    case (fs.sec)
      rhc_pkg::SEC_RED:   base_c = fs.neg ? H360 : '0;
      rhc_pkg::SEC_GREEN: base_c = H120;
      rhc_pkg::SEC_BLUE:  base_c = H240;
      default:            base_c = '0;
    endcase
    if (fs.grey) begin
      hue_c = '0;
      sat_c = '0;
    end else begin
      hue_c = fs.neg ? (base_c - hq_c - CW'(hrem_nz_c)) : (base_c + hq_c);
      sat_c = CW'(sacc[QMAX][QMAX-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid[QMAX];
    end
    result.hue           <= HUE_OW'(hue_c);
    result.saturation    <= SAT_OW'(sat_c);
    result.lightness_sum <= fs.sum;
  end

`ifndef SYNTHESIS
  // every accepted pixel comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted pixel did not produce a result on time");

  // no result word without a pixel taken the latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching pixel");

  // the difference in the hue numerator never exceeds delta
  a_absd: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> b_absd <= b_side.delta)
    else $error("hue difference larger than delta");

  // coloured pixels reach the dividers with non-zero divisors
  a_divisor: assert property (@(posedge clk) disable iff (rst)
    d_valid[0] && !d_side[0].grey |-> d_side[0].den != 8'd0 && d_side[0].delta != 8'd0)
    else $error("zero divisor on a coloured pixel");

  // hue stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    d_valid[QMAX] |-> hue_c < H360)
    else $error("hue out of range");
`endif

endmodule
